FILE: design/csa_pkg.sv
// Package with the request and response types, command codes and status codes of the allocator.
`timescale 1ns / 1ps
package csa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_BAD   = 2'd3
    } t_fit;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NO_OWNER = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  owner_id;
        logic [20:0] req_size;
        logic [1:0]  fit_mode;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] grant_start;
    } t_rsp;

    // One table entry as held in a cell.
    typedef struct packed {
        logic        used;
        logic        free;
        logic [7:0]  owner;
        logic [20:0] start;
        logic [20:0] len;
    } t_seg;

    // Operation that the controller broadcasts to every cell.
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_ROT  = 2'd1,
        OP_LOAD = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_FIX,
        S_RESP
    } t_state;

endpackage

FILE: design/csa_cell.sv
// One table slot of the rotating segment ring.
`timescale 1ns / 1ps
module csa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head,
    input  csa_pkg::t_op   i_op,
    input  csa_pkg::t_seg  i_prev,
    input  csa_pkg::t_seg  i_load,
    input  logic [20:0]    i_mem,
    output csa_pkg::t_seg  o_seg
);
    import csa_pkg::*;

    t_seg r_seg;
    t_seg n_seg;

    always_comb begin
        n_seg = r_seg;
        unique case (i_op)
            OP_HOLD: n_seg = r_seg;
            OP_ROT:  n_seg = i_prev;
            OP_LOAD: n_seg = i_load;
            default: n_seg = r_seg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.used  <= i_head;
            r_seg.free  <= 1'b1;
            r_seg.owner <= '0;
            r_seg.start <= '0;
            r_seg.len   <= i_head ? i_mem : 21'd0;
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;
endmodule

FILE: design/contiguous_segment_allocator_top.sv
// Top level of the contiguous segment allocator: controller around a ring of segment cells.
`timescale 1ns / 1ps
// The segment table lives in a ring of SEGS cells that rotates one slot per cycle
// during the scan and rebuild passes and holds otherwise; both passes read only the
// entry at the ring's head. Every command takes two full rotations: one to choose the
// target and one to build the new table, which is then loaded back into all cells at
// once in the FIX state. The response is registered in that state, and the next request
// is taken only once the response has been accepted.
module contiguous_segment_allocator_top #(
    parameter int MEM_SIZE = 1048576,
    parameter int SEGS     = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  csa_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output csa_pkg::t_rsp  o_rsp
);
    import csa_pkg::*;

    localparam int IW = $clog2(SEGS + 1);
    localparam int AW = $clog2(SEGS);
    localparam logic [20:0] MEM = 21'(MEM_SIZE);

    t_state r_state, n_state;
    t_req   r_req;
    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_pick;
    logic          r_found;
    logic [20:0]   r_keep;
    logic [IW-1:0] r_count;
    t_rsp          r_rsp;
    logic          r_ovalid;

    t_seg w_cell [SEGS];
    t_seg w_load [SEGS];
    t_op  w_op;
    t_seg w_head;

    assign w_head = w_cell[0];

    // Scan evaluation on the head entry.
    logic        w_live;
    logic        w_cand;
    logic [20:0] w_rem;
    always_comb begin
        w_live = (r_idx < r_count);
        w_rem  = w_head.len - r_req.req_size;
        w_cand = 1'b0;
        if (t_cmd'(r_req.cmd) == CMD_ALLOC) begin
            if (w_live && w_head.free && w_head.len >= r_req.req_size) begin
                unique case (t_fit'(r_req.fit_mode))
                    FIT_FIRST: w_cand = !r_found;
                    FIT_BEST:  w_cand = !r_found || w_rem < r_keep;
                    FIT_WORST: w_cand = !r_found || w_rem > r_keep;
                    default:   w_cand = 1'b0;
                endcase
            end
        end else begin
            w_cand = w_live && !r_found && !w_head.free && w_head.owner == r_req.owner_id;
        end
    end

    // Rebuild pass: the ring is re-emitted in order into a fresh list.
    t_seg r_out [SEGS];
    logic [IW-1:0] r_oc;
    logic [20:0]   r_addr;
    logic [AW-1:0] w_oc_a;
    logic [AW-1:0] w_oc_n;
    logic [AW-1:0] w_oc_p;

    assign w_oc_a = r_oc[AW-1:0];
    assign w_oc_n = AW'(r_oc + IW'(1));
    assign w_oc_p = AW'(r_oc - IW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SCAN;
            S_SCAN:  if (r_cnt == IW'(SEGS - 1)) n_state = S_APPLY;
            S_APPLY: if (r_cnt == IW'(SEGS - 1)) n_state = S_FIX;
            S_FIX:   n_state = S_RESP;
            S_RESP:  if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    logic w_nofit_early;
    assign w_nofit_early = (r_req.req_size == 21'd0) || (t_fit'(r_req.fit_mode) == FIT_BAD);

    // A split of the chosen hole needs a free table slot.
    logic    w_alloc_full;
    logic    w_alloc_ok;
    logic    w_wb;
    t_status w_status;
    logic [19:0] w_grant;

    assign w_alloc_full = (r_keep != 21'd0) && (r_count >= IW'(SEGS));
    assign w_alloc_ok   = !w_nofit_early && r_found && !w_alloc_full;
    assign w_wb = (t_cmd'(r_req.cmd) == CMD_ALLOC && w_alloc_ok) ||
                  (t_cmd'(r_req.cmd) == CMD_RELEASE && r_found) ||
                  (t_cmd'(r_req.cmd) == CMD_COMPACT);

    always_comb begin
        w_status = ST_OK;
        w_grant  = '0;
        case (t_cmd'(r_req.cmd))
            CMD_ALLOC: begin
                if (w_nofit_early || !r_found) begin
                    w_status = ST_NO_FIT;
                end else if (w_alloc_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_grant = r_out[r_pick[AW-1:0]].start[19:0];
                end
            end
            CMD_RELEASE: if (!r_found) w_status = ST_NO_OWNER;
            default: ;
        endcase
    end

    always_comb begin
        for (int k = 0; k < SEGS; k++) begin
            w_load[k] = w_cell[k];
            if (w_wb && IW'(k) < r_oc) begin
                w_load[k] = r_out[k];
            end else if (t_cmd'(r_req.cmd) == CMD_COMPACT && IW'(k) == r_oc &&
                         r_addr < MEM) begin
                w_load[k] = '{used: 1'b1, free: 1'b1, owner: 8'd0,
                              start: r_addr, len: MEM - r_addr};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count  <= IW'(1);
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req   <= i_req;
                        r_cnt   <= '0;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_keep  <= '0;
                        r_pick  <= '0;
                    end
                end
                S_SCAN: begin
                    if (w_cand) begin
                        r_found <= 1'b1;
                        r_pick  <= r_idx;
                        r_keep  <= w_rem;
                    end
                    if (r_cnt == IW'(SEGS - 1)) begin
                        r_cnt  <= '0;
                        r_idx  <= '0;
                        r_oc   <= '0;
                        r_addr <= '0;
                    end else begin
                        r_cnt <= r_cnt + IW'(1);
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_APPLY: begin
                    // Emit head into output list according to the command.
                    r_cnt <= r_cnt + IW'(1);
                    r_idx <= r_idx + IW'(1);
                    if (w_live) begin
                        unique case (t_cmd'(r_req.cmd))
                            CMD_ALLOC: begin
                                if (r_found && !w_nofit_early && r_idx == r_pick &&
                                    !(w_head.len > r_req.req_size && r_count >= IW'(SEGS))) begin
                                    r_out[w_oc_a] <= '{used: 1'b1, free: 1'b0,
                                        owner: r_req.owner_id, start: w_head.start,
                                        len: r_req.req_size};
                                    if (w_head.len > r_req.req_size) begin
                                        r_out[w_oc_n] <= '{used: 1'b1,
                                            free: 1'b1, owner: 8'd0,
                                            start: w_head.start + r_req.req_size,
                                            len: w_head.len - r_req.req_size};
                                        r_oc <= r_oc + IW'(2);
                                    end else begin
                                        r_oc <= r_oc + IW'(1);
                                    end
                                end else begin
                                    r_out[w_oc_a] <= w_head;
                                    r_oc <= r_oc + IW'(1);
                                end
                            end
                            CMD_RELEASE: begin
                                // Free the picked entry and merge with a free predecessor.
                                if ((r_found && r_idx == r_pick) || w_head.free) begin
                                    if (r_oc != '0 && r_out[w_oc_p].free) begin
                                        r_out[w_oc_p].len <= r_out[w_oc_p].len + w_head.len;
                                    end else begin
                                        r_out[w_oc_a] <= '{used: 1'b1, free: 1'b1,
                                            owner: 8'd0, start: w_head.start,
                                            len: w_head.len};
                                        r_oc <= r_oc + IW'(1);
                                    end
                                end else begin
                                    r_out[w_oc_a] <= w_head;
                                    r_oc <= r_oc + IW'(1);
                                end
                            end
                            CMD_COMPACT: begin
                                if (!w_head.free) begin
                                    r_out[w_oc_a] <= '{used: 1'b1, free: 1'b0,
                                        owner: w_head.owner, start: r_addr,
                                        len: w_head.len};
                                    r_addr <= r_addr + w_head.len;
                                    r_oc   <= r_oc + IW'(1);
                                end
                            end
                            default: begin
                                r_out[w_oc_a] <= w_head;
                                r_oc <= r_oc + IW'(1);
                            end
                        endcase
                    end
                end
                S_FIX: begin
                    r_rsp    <= '{status: w_status, grant_start: w_grant};
                    r_ovalid <= 1'b1;
                    if (t_cmd'(r_req.cmd) == CMD_COMPACT) begin
                        r_count <= (r_addr < MEM && r_oc < IW'(SEGS)) ? r_oc + IW'(1) : r_oc;
                    end else if (w_wb) begin
                        r_count <= r_oc;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    // The ring rotates during both passes and takes the rebuilt table at the end.
    assign w_op = (r_state == S_SCAN || r_state == S_APPLY) ? OP_ROT :
                  (r_state == S_FIX) ? OP_LOAD : OP_HOLD;

    for (genvar g = 0; g < SEGS; g++) begin : g_cell
        csa_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_head (g == 0),
            .i_op   (w_op),
            .i_prev (w_cell[(g + 1) % SEGS]),
            .i_load (w_load[g]),
            .i_mem  (MEM),
            .o_seg  (w_cell[g])
        );
    end

    property p_one_side;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !o_ready;
    endproperty
    a_one_side: assert property (p_one_side) else $error("ready while response pending");

    property p_count;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= IW'(SEGS);
    endproperty
    a_count: assert property (p_count) else $error("segment count overflow");

    property p_accept_idle;
        @(posedge i_clk) disable iff (!i_rst_n) (i_valid && o_ready) |=> r_state == S_SCAN;
    endproperty
    a_accept_idle: assert property (p_accept_idle) else $error("request not started");
endmodule

FILE: tb/sv/contiguous_segment_allocator_checker.sv
// Checker that predicts the allocator's responses and compares them with the response channel.
`timescale 1ns / 1ps
module contiguous_segment_allocator_checker #(
    parameter int MEM_SIZE = 1048576,
    parameter int SEGS     = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  csa_pkg::t_req  i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  csa_pkg::t_rsp  i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    import csa_pkg::*;

    logic [20:0] seg_base [SEGS];
    logic [20:0] seg_len  [SEGS];
    logic [7:0]  seg_owner[SEGS];
    logic        seg_free [SEGS];
    int          seg_total;
    t_rsp        expected_rsp[$];

    assign o_pending = expected_rsp.size();

    function automatic void remove_segment(int k);
        for (int i = k; i + 1 < seg_total; i++) begin
            seg_base[i]  = seg_base[i + 1];
            seg_len[i]   = seg_len[i + 1];
            seg_owner[i] = seg_owner[i + 1];
            seg_free[i]  = seg_free[i + 1];
        end
        seg_total--;
    endfunction

    function automatic t_rsp predict_response(t_req r);
        t_rsp        rsp;
        int          pick;
        int          j;
        logic [20:0] keep;
        logic [20:0] rem;
        logic [20:0] addr;
        rsp = '0;
        case (t_cmd'(r.cmd))
            CMD_ALLOC: begin
                pick = -1;
                keep = '0;
                if (r.req_size != 0 && t_fit'(r.fit_mode) != FIT_BAD) begin
                    for (int i = 0; i < seg_total; i++) begin
                        if (!seg_free[i] || seg_len[i] < r.req_size)
                            continue;
                        rem = seg_len[i] - r.req_size;
                        if (t_fit'(r.fit_mode) == FIT_FIRST) begin
                            pick = i;
                            break;
                        end
                        if (pick < 0 || (t_fit'(r.fit_mode) == FIT_BEST ? rem < keep
                                                                         : rem > keep)) begin
                            pick = i;
                            keep = rem;
                        end
                    end
                end
                if (pick < 0) begin
                    rsp.status = ST_NO_FIT;
                end else if (seg_len[pick] > r.req_size && seg_total >= SEGS) begin
                    rsp.status = ST_FULL;
                end else begin
                    if (seg_len[pick] > r.req_size) begin
                        for (int i = seg_total; i > pick + 1; i--) begin
                            seg_base[i]  = seg_base[i - 1];
                            seg_len[i]   = seg_len[i - 1];
                            seg_owner[i] = seg_owner[i - 1];
                            seg_free[i]  = seg_free[i - 1];
                        end
                        seg_total++;
                        seg_base[pick + 1]  = seg_base[pick] + r.req_size;
                        seg_len[pick + 1]   = seg_len[pick] - r.req_size;
                        seg_owner[pick + 1] = '0;
                        seg_free[pick + 1]  = 1'b1;
                        seg_len[pick]       = r.req_size;
                    end
                    seg_owner[pick]  = r.owner_id;
                    seg_free[pick]   = 1'b0;
                    rsp.status       = ST_OK;
                    rsp.grant_start  = seg_base[pick][19:0];
                end
            end
            CMD_RELEASE: begin
                pick = -1;
                for (int i = 0; i < seg_total; i++) begin
                    if (!seg_free[i] && seg_owner[i] == r.owner_id) begin
                        pick = i;
                        break;
                    end
                end
                if (pick < 0) begin
                    rsp.status = ST_NO_OWNER;
                end else begin
                    seg_free[pick]  = 1'b1;
                    seg_owner[pick] = '0;
                    if (pick + 1 < seg_total && seg_free[pick + 1]) begin
                        seg_len[pick] += seg_len[pick + 1];
                        remove_segment(pick + 1);
                    end
                    if (pick > 0 && seg_free[pick - 1]) begin
                        seg_len[pick - 1] += seg_len[pick];
                        remove_segment(pick);
                    end
                end
            end
            CMD_COMPACT: begin
                j = 0;
                addr = '0;
                for (int i = 0; i < seg_total; i++) begin
                    if (seg_free[i])
                        continue;
                    seg_base[j]  = addr;
                    seg_len[j]   = seg_len[i];
                    seg_owner[j] = seg_owner[i];
                    seg_free[j]  = 1'b0;
                    addr += seg_len[i];
                    j++;
                end
                if (addr < MEM_SIZE && j < SEGS) begin
                    seg_base[j]  = addr;
                    seg_len[j]   = 21'(MEM_SIZE) - addr;
                    seg_owner[j] = '0;
                    seg_free[j]  = 1'b1;
                    j++;
                end
                seg_total = j;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < SEGS; i++) begin
                seg_base[i]  = '0;
                seg_len[i]   = '0;
                seg_owner[i] = '0;
                seg_free[i]  = 1'b0;
            end
            seg_len[0]   = 21'(MEM_SIZE);
            seg_free[0]  = 1'b1;
            seg_total    = 1;
            o_fail_count = 0;
            expected_rsp.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                expected_rsp.push_back(predict_response(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%t: response with none expected: status %0d start %0d",
                             $time, i_rsp.status, i_rsp.grant_start);
                    o_fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (want.status != i_rsp.status) begin
                        $display("%t: status expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (want.grant_start != i_rsp.grant_start) begin
                        $display("%t: grant_start expected %0d actual %0d",
                                 $time, want.grant_start, i_rsp.grant_start);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/contiguous_segment_allocator_top_tb.sv
// Testbench top that drives requests into the allocator and reports the verdict.
`timescale 1ns / 1ps
module contiguous_segment_allocator_top_tb;
    import csa_pkg::*;

    localparam int MEM_SIZE = 1048576;
    localparam int SEGS     = 32;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_rsp  o_rsp;
    int    fail_count;
    int    pending;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    long_stall;

    contiguous_segment_allocator_top #(.MEM_SIZE(MEM_SIZE), .SEGS(SEGS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    contiguous_segment_allocator_checker #(.MEM_SIZE(MEM_SIZE), .SEGS(SEGS)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_valid), .i_req_ready(o_ready), .i_req(i_req),
        .i_rsp_valid(o_valid), .i_rsp_ready(i_ready), .i_rsp(o_rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // The receiver holds off for a long stretch when asked, otherwise stalls at random.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_stall = 1'b0;
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_request(t_cmd c, logic [7:0] owner, logic [20:0] size, t_fit fit);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= '{cmd: c, owner_id: owner, req_size: size, fit_mode: fit};
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int          pick;
        logic [7:0]  owner;
        logic [20:0] size;
        t_fit        fit;
        pick  = $urandom_range(0, 99);
        owner = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       size = 21'($urandom_range(0, 2097151));
            1, 2:    size = 21'($urandom_range(1, MEM_SIZE));
            default: size = 21'($urandom_range(1, 4096));
        endcase
        fit = ($urandom_range(0, 19) == 0) ? FIT_BAD : t_fit'($urandom_range(0, 2));
        if (pick < 55)
            send_request(CMD_ALLOC, owner, size, fit);
        else if (pick < 93)
            send_request(CMD_RELEASE, owner, size, fit);
        else if (pick < 98)
            send_request(CMD_COMPACT, owner, size, fit);
        else
            send_request(CMD_NOP, owner, size, fit);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req          = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_stall     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_ALLOC, 8'd1, 21'd1, FIT_FIRST);
        send_request(CMD_ALLOC, 8'd2, 21'd1048576, FIT_FIRST);
        send_request(CMD_ALLOC, 8'd2, 21'd0, FIT_BEST);
        send_request(CMD_ALLOC, 8'd2, 21'h1FFFFF, FIT_WORST);
        send_request(CMD_ALLOC, 8'd2, 21'd10, FIT_BAD);
        send_request(CMD_RELEASE, 8'd99, 21'd0, FIT_FIRST);
        send_request(CMD_ALLOC, 8'd255, 21'd100, FIT_BEST);
        send_request(CMD_ALLOC, 8'd3, 21'd200, FIT_WORST);
        send_request(CMD_ALLOC, 8'd4, 21'd50, FIT_FIRST);
        send_request(CMD_RELEASE, 8'd1, 21'd0, FIT_FIRST);
        send_request(CMD_RELEASE, 8'd255, 21'd0, FIT_FIRST);
        send_request(CMD_ALLOC, 8'd5, 21'd30, FIT_BEST);
        send_request(CMD_ALLOC, 8'd6, 21'd30, FIT_WORST);
        send_request(CMD_COMPACT, 8'd0, 21'd0, FIT_FIRST);
        send_request(CMD_ALLOC, 8'd0, 21'd1048236, FIT_FIRST);
        send_request(CMD_ALLOC, 8'd7, 21'd1, FIT_FIRST);
        send_request(CMD_COMPACT, 8'd0, 21'd0, FIT_FIRST);
        send_request(CMD_NOP, 8'd255, 21'h1FFFFF, FIT_BAD);
        send_request(CMD_RELEASE, 8'd0, 21'd0, FIT_FIRST);
        send_request(CMD_RELEASE, 8'd3, 21'd0, FIT_FIRST);
        for (int i = 0; i < 20; i++)
            send_request(CMD_ALLOC, 8'(i), 21'd16, FIT_BEST);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 1) ? 58 : 37) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 58 : 37) : 0;
            for (int i = 0; i < 345; i++) begin
                if (p == 0 && i == 100) begin
                    @(negedge i_clk);
                    long_stall = 1'b1;
                    @(posedge i_clk);
                end
                if (p == 2 && i == 150)
                    wait_drained();
                send_random_request();
            end
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
